// ===== sv/chrom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrom_pkg
// Shared types, constants and helpers of the character rom access port.
// ----------------------------------------------------------------------------
package chrom_pkg;

  // widths
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned LINE_W = 4;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned LEVEL_W = 2;

  // bus access codes
  typedef enum logic [OP_W-1:0] {
    OP_CODE_HI = 3'd0,
    OP_CODE_LO = 3'd1,
    OP_LINE    = 3'd2,
    OP_PAT_WR  = 3'd3,
    OP_PAT_RD  = 3'd4
  } op_t;

  // address constants
  localparam logic [ADDR_W-1:0] WIN_IDLE    = 20'h7fff0;
  localparam logic [ADDR_W-1:0] ROM_HALF    = 20'h80000;
  localparam logic [ADDR_W-1:0] HALF_OFFSET = 20'h00800;
  localparam logic [CODE_W-1:0] KANJI_MASK  = 16'h7f7f;

  // window mapping needs this chip level or higher
  localparam logic [LEVEL_W-1:0] LEVEL_WINDOW = 2'd2;

  // user-definable character codes (low seven bits)
  localparam logic [6:0] USER_FIRST   = 7'h56;
  localparam logic [6:0] USER_END     = 7'h58;
  localparam logic [6:0] HALF_A_FIRST = 7'h0c;
  localparam logic [6:0] HALF_A_END   = 7'h10;
  localparam logic [6:0] HALF_B_END   = 7'h60;
  localparam logic [6:0] FULL_END     = 7'h08;
  localparam logic [6:0] USER_PAIR_MASK = 7'h7e;

  // line/half byte fields
  localparam int unsigned RIGHT_BIT = 5;

  // memory window seen by the host
  typedef struct packed {
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
    logic              user_writable;
  } window_t;

  // base of a two-byte code in the kanji area
  function automatic logic [ADDR_W-1:0] kanji_base(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] masked;
    masked = code & KANJI_MASK;
    return {masked, 4'h0};
  endfunction

  // byte offset of the selected half
  function automatic logic [ADDR_W-1:0] half_offset(input logic left_half);
    return left_half ? HALF_OFFSET : '0;
  endfunction

endpackage

// ===== sv/chrom_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrom_in_if
// Bus access channel: one word per access.
// ----------------------------------------------------------------------------
interface chrom_in_if;
  logic                           valid;
  logic                           ready;
  logic [chrom_pkg::OP_W-1:0]     operation;
  logic [chrom_pkg::DATA_W-1:0]   bus_data;

  modport source (output valid, operation, bus_data, input ready);
  modport sink (input valid, operation, bus_data, output ready);
endinterface

// ===== sv/chrom_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrom_out_if
// Result channel: font strobes, window and flags, one word per access.
// ----------------------------------------------------------------------------
interface chrom_out_if;
  logic                           valid;
  logic                           ready;
  logic [chrom_pkg::ADDR_W-1:0]   font_address;
  logic                           font_write;
  logic                           font_read;
  logic [chrom_pkg::ADDR_W-1:0]   window_low;
  logic [chrom_pkg::ADDR_W-1:0]   window_high;
  logic                           window_user_writable;
  logic                           font_modified;

  modport source (output valid, font_address, font_write, font_read, window_low,
                  window_high, window_user_writable, font_modified, input ready);
  modport sink (input valid, font_address, font_write, font_read, window_low,
                window_high, window_user_writable, font_modified, output ready);
endinterface

// ===== sv/chrom_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrom_window
// Memory window mapping from character code, half and chip level.
// ----------------------------------------------------------------------------
module chrom_window (
  input  logic [chrom_pkg::LEVEL_W-1:0] chip_level,
  input  logic [chrom_pkg::CODE_W-1:0]  char_code,
  input  logic                          left_half,
  output chrom_pkg::window_t            window
);

  logic [chrom_pkg::ADDR_W-1:0] base;
  logic [chrom_pkg::ADDR_W-1:0] half;
  logic [6:0]                   c;

  assign base = chrom_pkg::kanji_base(char_code);
  assign half = chrom_pkg::half_offset(left_half);
  assign c    = char_code[6:0];

  // window selection by code class
  always_comb begin
    window.low           = chrom_pkg::WIN_IDLE;
    window.high          = chrom_pkg::WIN_IDLE;
    window.user_writable = 1'b0;
    if (chip_level >= chrom_pkg::LEVEL_WINDOW) begin
      if (char_code[15:8] == '0) begin
        window.high = chrom_pkg::ROM_HALF + {4'h0, char_code[11:0], 4'h0};
      end else if (c >= chrom_pkg::USER_FIRST && c < chrom_pkg::USER_END) begin
        window.user_writable = 1'b1;
        window.high          = base + half;
      end else if ((c >= chrom_pkg::HALF_A_FIRST && c < chrom_pkg::HALF_A_END) ||
                   (c >= chrom_pkg::USER_END && c < chrom_pkg::HALF_B_END)) begin
        window.high = base + half;
      end else if (c < chrom_pkg::FULL_END || c >= chrom_pkg::HALF_A_END) begin
        window.low  = base;
        window.high = base + chrom_pkg::HALF_OFFSET;
      end else begin
        window.high = base;
      end
    end
  end

endmodule

// ===== sv/character_rom_access_port_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// character_rom_access_port_top
// Character generator access port: code, line and half registers, font
// address and strobes, memory window and modified flag.
// ----------------------------------------------------------------------------
// One bus access per cycle: each accepted word is decoded against the held
// code, line and half, and its result word is in the output register on the
// next cycle. A new word is taken whenever the output register is empty or
// is being read in the same cycle, so accesses stall only while the receiver
// holds a full output register. chip_level is written through the cfg port at
// any time (always ready) and takes effect at the next code or line/half write.

module character_rom_access_port_top (
  input  logic                          clk,
  input  logic                          rst,
  chrom_in_if.sink                      in,
  chrom_out_if.source                   out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [chrom_pkg::LEVEL_W-1:0] cfg_data
);

  logic [chrom_pkg::LEVEL_W-1:0] chip_level;
  logic [chrom_pkg::CODE_W-1:0]  char_code;
  logic [chrom_pkg::CODE_W-1:0]  char_code_next;
  logic [chrom_pkg::LINE_W-1:0]  glyph_line;
  logic [chrom_pkg::LINE_W-1:0]  glyph_line_next;
  logic                          left_half;
  logic                          left_half_next;
  chrom_pkg::window_t            window;
  chrom_pkg::window_t            window_next;
  chrom_pkg::window_t            window_calc;
  logic                          modified;
  logic                          modified_next;

  logic                          accept;
  logic                          update_window;
  chrom_pkg::op_t                op;
  logic [chrom_pkg::ADDR_W-1:0]  kanji_addr;
  logic [chrom_pkg::ADDR_W-1:0]  addr_next;
  logic                          wr_next;
  logic                          rd_next;

  logic                          res_valid;
  logic [chrom_pkg::ADDR_W-1:0]  res_addr;
  logic                          res_wr;
  logic                          res_rd;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in.ready  = !res_valid || out.ready;
  assign accept    = in.valid && in.ready;
  assign op        = chrom_pkg::op_t'(in.operation);

  // font address from the held code
  assign kanji_addr = chrom_pkg::kanji_base(char_code) + chrom_pkg::half_offset(left_half)
                      + {{(chrom_pkg::ADDR_W-chrom_pkg::LINE_W){1'b0}}, glyph_line};

  // access decode
  always_comb begin
    char_code_next  = char_code;
    glyph_line_next = glyph_line;
    left_half_next  = left_half;
    modified_next   = modified;
    update_window   = 1'b0;
    addr_next       = '0;
    wr_next         = 1'b0;
    rd_next         = 1'b0;
    unique case (op)
      chrom_pkg::OP_CODE_HI: begin
        char_code_next = {in.bus_data, char_code[7:0]};
        update_window  = 1'b1;
      end
      chrom_pkg::OP_CODE_LO: begin
        char_code_next = {char_code[15:8], in.bus_data};
        update_window  = 1'b1;
      end
      chrom_pkg::OP_LINE: begin
        glyph_line_next = in.bus_data[chrom_pkg::LINE_W-1:0];
        left_half_next  = !in.bus_data[chrom_pkg::RIGHT_BIT];
        update_window   = 1'b1;
      end
      chrom_pkg::OP_PAT_WR: begin
        addr_next = kanji_addr;
        if ((char_code[6:0] & chrom_pkg::USER_PAIR_MASK) == chrom_pkg::USER_FIRST) begin
          wr_next       = 1'b1;
          modified_next = 1'b1;
        end
      end
      chrom_pkg::OP_PAT_RD: begin
        rd_next = 1'b1;
        if (char_code[15:8] != '0) begin
          addr_next = kanji_addr;
        end else begin
          addr_next = chrom_pkg::ROM_HALF + {4'h0, char_code[11:0], 4'h0}
                      + {{(chrom_pkg::ADDR_W-chrom_pkg::LINE_W){1'b0}}, glyph_line};
        end
      end
      default: begin
      end
    endcase
  end

  // window from the updated code and half
  chrom_window u_window (
    .chip_level (chip_level),
    .char_code  (char_code_next),
    .left_half  (left_half_next),
    .window     (window_calc)
  );

  assign window_next = update_window ? window_calc : window;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      chip_level <= cfg_data;
    end
  end

  // access state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_code  <= '0;
      glyph_line <= '0;
      left_half  <= 1'b0;
      window     <= '{low: chrom_pkg::WIN_IDLE, high: chrom_pkg::WIN_IDLE,
                      user_writable: 1'b0};
      modified   <= 1'b0;
    end else if (accept) begin
      char_code  <= char_code_next;
      glyph_line <= glyph_line_next;
      left_half  <= left_half_next;
      window     <= window_next;
      modified   <= modified_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in.ready) begin
      res_valid <= in.valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_addr <= addr_next;
      res_wr   <= wr_next;
      res_rd   <= rd_next;
    end
  end

  // result word; window and flags follow the state left by the access
  assign out.valid                = res_valid;
  assign out.font_address         = res_addr;
  assign out.font_write           = res_wr;
  assign out.font_read            = res_rd;
  assign out.window_low           = window.low;
  assign out.window_high          = window.high;
  assign out.window_user_writable = window.user_writable;
  assign out.font_modified        = modified;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the character rom access port one bus access at a time. A local
// copy of the code, line, half, window and modified state works out the
// result word of every accepted access, and each result word that leaves
// the block is compared with it field by field. Directed accesses come
// first, then random glyph sequences under several chip levels and idle
// patterns, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import chrom_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP   = 40;
  localparam int unsigned DRAIN_GAP   = 3;

  // operation codes that the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] font_address;
    logic              font_write;
    logic              font_read;
    logic [ADDR_W-1:0] window_low;
    logic [ADDR_W-1:0] window_high;
    logic              window_user_writable;
    logic              font_modified;
  } font_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid;
  logic cfg_ready;
  logic [LEVEL_W-1:0] cfg_data;

  chrom_in_if  acc_ch ();
  chrom_out_if res_ch ();

  character_rom_access_port_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in        (acc_ch),
    .out       (res_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // local copy of the port state
  logic [LEVEL_W-1:0] pred_level     = '0;
  logic [CODE_W-1:0]  pred_code      = '0;
  logic [LINE_W-1:0]  pred_line      = '0;
  logic               pred_left      = 1'b0;
  logic [ADDR_W-1:0]  pred_win_low   = WIN_IDLE;
  logic [ADDR_W-1:0]  pred_win_high  = WIN_IDLE;
  logic               pred_user_wr   = 1'b0;
  logic               pred_modified  = 1'b0;

  font_result_t pending_font_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int accesses_sent = 0;
  int mismatches    = 0;
  int words_checked = 0;
  int cycle_count   = 0;
  int pat_writes_done = 0;
  int pat_writes_refused = 0;
  int pat_reads_done = 0;
  int user_windows  = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // window for the held code and half at the current chip level
  function automatic void remap_window();
    logic [6:0]        c;
    logic [ADDR_W-1:0] half;
    c = pred_code[6:0];
    half = pred_left ? HALF_OFFSET : '0;
    pred_win_low = WIN_IDLE;
    pred_user_wr = 1'b0;
    if (pred_level >= LEVEL_WINDOW) begin
      if (pred_code[15:8] == 8'h00) begin
        pred_win_high = ROM_HALF + {pred_code, 4'h0};
      end else begin
        pred_win_high = {pred_code & KANJI_MASK, 4'h0};
        if (c >= USER_FIRST && c < USER_END) begin
          pred_user_wr = 1'b1;
          pred_win_high = pred_win_high + half;
        end else if ((c >= HALF_A_FIRST && c < HALF_A_END) ||
                     (c >= USER_END && c < HALF_B_END)) begin
          pred_win_high = pred_win_high + half;
        end else if (c < FULL_END || c >= HALF_A_END) begin
          pred_win_low = pred_win_high;
          pred_win_high = pred_win_high + HALF_OFFSET;
        end
      end
    end else begin
      pred_win_high = pred_win_low;
    end
  endfunction

  // apply one accepted access and queue the word it should produce
  function automatic void predict_access(input logic [OP_W-1:0] op,
                                         input logic [DATA_W-1:0] data);
    font_result_t      r;
    logic [ADDR_W-1:0] kanji_addr;
    kanji_addr = {pred_code & KANJI_MASK, 4'h0} + (pred_left ? HALF_OFFSET : '0)
                 + ADDR_W'(pred_line);
    r = '0;
    case (op)
      OP_CODE_HI: begin
        pred_code[15:8] = data;
        remap_window();
      end
      OP_CODE_LO: begin
        pred_code[7:0] = data;
        remap_window();
      end
      OP_LINE: begin
        pred_line = data[LINE_W-1:0];
        pred_left = !data[RIGHT_BIT];
        remap_window();
      end
      OP_PAT_WR: begin
        r.font_address = kanji_addr;
        if ((pred_code[6:0] & USER_PAIR_MASK) == USER_FIRST) begin
          r.font_write = 1'b1;
          pred_modified = 1'b1;
          pat_writes_done++;
        end else begin
          pat_writes_refused++;
        end
      end
      OP_PAT_RD: begin
        if (pred_code[15:8] != 8'h00)
          r.font_address = kanji_addr;
        else
          r.font_address = ROM_HALF + {pred_code, 4'h0} + ADDR_W'(pred_line);
        r.font_read = 1'b1;
        pat_reads_done++;
      end
      default: ;
    endcase
    if (pred_user_wr)
      user_windows++;
    r.window_low = pred_win_low;
    r.window_high = pred_win_high;
    r.window_user_writable = pred_user_wr;
    r.font_modified = pred_modified;
    pending_font_results.push_back(r);
  endfunction

  // accepted accesses and level writes feed the local copy
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready)
      pred_level = cfg_data;
    if (!rst && acc_ch.valid && acc_ch.ready)
      predict_access(acc_ch.operation, acc_ch.bus_data);
  end

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s got %05h want %05h", $time, field, got, want);
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    font_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      words_checked++;
      if (pending_font_results.size() == 0) begin
        report_mismatch("unexpected word, font_address", res_ch.font_address, '0);
      end else begin
        want = pending_font_results.pop_front();
        if (res_ch.font_address !== want.font_address)
          report_mismatch("font_address", res_ch.font_address, want.font_address);
        if (res_ch.font_write !== want.font_write)
          report_mismatch("font_write", ADDR_W'(res_ch.font_write), ADDR_W'(want.font_write));
        if (res_ch.font_read !== want.font_read)
          report_mismatch("font_read", ADDR_W'(res_ch.font_read), ADDR_W'(want.font_read));
        if (res_ch.window_low !== want.window_low)
          report_mismatch("window_low", res_ch.window_low, want.window_low);
        if (res_ch.window_high !== want.window_high)
          report_mismatch("window_high", res_ch.window_high, want.window_high);
        if (res_ch.window_user_writable !== want.window_user_writable)
          report_mismatch("window_user_writable", ADDR_W'(res_ch.window_user_writable),
                          ADDR_W'(want.window_user_writable));
        if (res_ch.font_modified !== want.font_modified)
          report_mismatch("font_modified", ADDR_W'(res_ch.font_modified),
                          ADDR_W'(want.font_modified));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // offer one access word and wait until it is taken
  task automatic send_access(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      acc_ch.valid <= 1'b0;
      @(posedge clk);
    end
    acc_ch.valid <= 1'b1;
    acc_ch.operation <= op;
    acc_ch.bus_data <= data;
    do @(posedge clk); while (!acc_ch.ready);
    if (op <= OP_PAT_RD)
      accesses_sent++;
  endtask

  // stop sending and wait until every expected word has come back
  task automatic wait_drained();
    acc_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_font_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // chip level write, only with the block idle
  task automatic write_level(input logic [LEVEL_W-1:0] lvl);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= lvl;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // code, usually a line/half write, then one to six pattern accesses
  task automatic send_glyph_sequence();
    logic [7:0] hi;
    logic [7:0] lo;
    int         n;
    hi = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    case ($urandom_range(5))
      0: lo = {1'($urandom), 6'h2b, 1'($urandom)};
      1: lo = {1'($urandom), 7'($urandom_range(12, 15))};
      2: lo = {1'($urandom), 7'($urandom_range(88, 95))};
      3: lo = {1'($urandom), 7'($urandom_range(0, 15))};
      default: lo = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: send_access(OP_CODE_HI, hi);
      1: send_access(OP_CODE_LO, lo);
      2: begin
        send_access(OP_CODE_LO, lo);
        send_access(OP_CODE_HI, hi);
      end
      default: begin
        send_access(OP_CODE_HI, hi);
        send_access(OP_CODE_LO, lo);
      end
    endcase
    if ($urandom_range(4) != 0)
      send_access(OP_LINE, 8'($urandom));
    n = $urandom_range(1, 6);
    repeat (n)
      send_access($urandom_range(1) ? OP_PAT_WR : OP_PAT_RD, 8'($urandom));
  endtask

  // a block of random traffic at one chip level
  task automatic run_random_block(input int n_items, input logic [LEVEL_W-1:0] lvl);
    int start;
    write_level(lvl);
    start = accesses_sent;
    while (accesses_sent - start < n_items) begin
      if ($urandom_range(99) < 85)
        send_glyph_sequence();
      else
        send_access(OP_W'($urandom_range(7)), 8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes, each operation, refused writes, level change timing
  task automatic test_directed();
    send_access(OP_PAT_RD, 8'hff);
    send_access(OP_PAT_WR, 8'h00);
    send_access(OP_SPARE_FIRST, 8'hff);
    send_access(OP_SPARE_MID, 8'h00);
    send_access(OP_SPARE_LAST, 8'ha5);
    send_access(OP_CODE_HI, 8'hff);
    send_access(OP_CODE_LO, 8'hd6);
    write_level(2'd3);
    send_access(OP_LINE, 8'h0f);
    send_access(OP_PAT_WR, 8'hff);
    send_access(OP_PAT_RD, 8'h00);
    send_access(OP_CODE_LO, 8'h0c);
    send_access(OP_CODE_LO, 8'h5f);
    send_access(OP_CODE_LO, 8'h07);
    send_access(OP_CODE_LO, 8'h0a);
    send_access(OP_CODE_LO, 8'h7f);
    send_access(OP_LINE, 8'hff);
    send_access(OP_PAT_WR, 8'h5a);
    send_access(OP_CODE_HI, 8'h00);
    send_access(OP_PAT_WR, 8'h81);
    send_access(OP_PAT_RD, 8'h3c);
    // level drop shows only at the next code write
    write_level(2'd0);
    send_access(OP_PAT_RD, 8'h00);
    send_access(OP_CODE_LO, 8'h57);
    write_level(2'd1);
    send_access(OP_CODE_HI, 8'h80);
    send_access(OP_PAT_WR, 8'hc3);
  endtask

  // three idle patterns, a range of chip levels
  task automatic test_random_traffic();
    send_idle_pct = 14;
    recv_idle_pct = 56;
    run_random_block(200, 2'd2);
    run_random_block(200, 2'd0);
    run_random_block(200, 2'd3);
    send_idle_pct = 56;
    recv_idle_pct = 14;
    run_random_block(200, 2'd1);
    run_random_block(200, 2'd3);
    run_random_block(200, 2'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_block(200, 2'd0);
    run_random_block(200, 2'd1);
    run_random_block(200, 2'd3);
  endtask

  // long receiver hold-off with the sender pushing, then a full pause
  task automatic test_backpressure();
    write_level(2'd2);
    send_idle_pct = 0;
    recv_idle_pct = 30;
    hold_left = 150;
    repeat (6) send_glyph_sequence();
    wait_drained();
    repeat (4) send_glyph_sequence();
  endtask

  initial begin
    acc_ch.valid = 1'b0;
    acc_ch.operation = OP_CODE_HI;
    acc_ch.bus_data = '0;
    res_ch.ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_backpressure();
    wait_drained();

    $display("%0d accesses, %0d result words checked, chip levels 0 to 3",
             accesses_sent, words_checked);
    $display("pattern writes %0d taken / %0d refused, %0d reads, %0d user windows",
             pat_writes_done, pat_writes_refused, pat_reads_done, user_windows);
    if (mismatches == 0 && pending_font_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches,
               pending_font_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
